// ----- rtl/car_pkg.sv -----
// ----------------------------------------------------------------------------
// CAR page replacement package
// Shared constants, the directory class codes and their type.
// ----------------------------------------------------------------------------
package car_pkg;

  // Default sizes of the engine
  localparam int FRAMES_DEF           = 64;
  localparam int GHOST_LIMIT_DEF      = 128;
  localparam int PAGE_NUMBER_BITS_DEF = 20;
  localparam int PAGE_OFFSET_BITS_DEF = 12;

  // Width of the byte address word
  localparam int ADDRESS_W = 32;

  // Directory class of a page
  localparam int CLS_W = 3;
  typedef logic [CLS_W-1:0] cls_t;

  localparam cls_t CLS_ABSENT = 3'd0;
  localparam cls_t CLS_T1     = 3'd1;
  localparam cls_t CLS_T2     = 3'd2;
  localparam cls_t CLS_B1     = 3'd3;
  localparam cls_t CLS_B2     = 3'd4;

endpackage

// ----- rtl/car_req_if.sv -----
// ----------------------------------------------------------------------------
// CAR request channel
// Carries one byte address word per handshake.
// ----------------------------------------------------------------------------
interface car_req_if;

  logic                          valid;
  logic                          ready;
  logic [car_pkg::ADDRESS_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);

endinterface

// ----- rtl/car_rsp_if.sv -----
// ----------------------------------------------------------------------------
// CAR response channel
// Carries the loaded frame and the page number placed in it.
// ----------------------------------------------------------------------------
interface car_rsp_if #(
  parameter int FRAME_W = 6,
  parameter int PAGE_W  = 20
);

  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame;
  logic [PAGE_W-1:0]  page;

  modport source (output valid, output frame, output page, input ready);
  modport sink (input valid, input frame, input page, output ready);

endinterface

// ----- rtl/car_ram.sv -----
// ----------------------------------------------------------------------------
// CAR generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module car_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/car_page_replacement_top.sv -----
// ----------------------------------------------------------------------------
// CAR page replacement engine
// Clock with Adaptive Replacement over FRAMES frames, state held in RAMs.
// ----------------------------------------------------------------------------
// Each request word is a byte address; its page is looked up in a directory
// RAM with one entry per page. A hit sets the page's reference bit and gives
// no response. A miss while frames are free returns one response word
// (frame, page). A miss with every frame in use first sweeps the clocks slot
// by slot, retires the victim to its ghost list and may trim a ghost entry; a
// ghost hit adds a serial divider, then adapts the target and unlinks the
// ghost node. The directory and clock RAMs each have one read and one write
// port and are walked one access per cycle. After reset the directory is
// cleared one entry a cycle, all 2**PAGE_NUMBER_BITS entries, during which no
// request is taken. A finished response waits in an output register while
// the next request is accepted.
// ----------------------------------------------------------------------------
module car_page_replacement_top #(
  parameter int FRAMES           = car_pkg::FRAMES_DEF,
  parameter int GHOST_LIMIT      = car_pkg::GHOST_LIMIT_DEF,
  parameter int PAGE_NUMBER_BITS = car_pkg::PAGE_NUMBER_BITS_DEF,
  parameter int PAGE_OFFSET_BITS = car_pkg::PAGE_OFFSET_BITS_DEF
) (
  input logic     clk,
  input logic     rst,
  car_req_if.sink req,
  car_rsp_if.source rsp
);

  localparam int PNB = PAGE_NUMBER_BITS;
  localparam int FB  = $clog2(FRAMES);
  localparam int CW  = $clog2(FRAMES + 1);
  localparam int NB  = $clog2(GHOST_LIMIT);
  localparam int GW  = $clog2(GHOST_LIMIT + 1);
  localparam int IW  = (FB > NB) ? FB : NB;
  localparam int DW  = car_pkg::CLS_W + IW;
  localparam int CPW = PNB + FB;
  localparam int TW  = ((CW > GW) ? CW : GW) + 2;
  localparam int SW  = ((CW > GW) ? CW : GW) + 1;
  localparam int DSW = $clog2(GW + 1);

  localparam logic [NB:0] NIL = {1'b1, {NB{1'b0}}};

  // Sequencer states
  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DIR      = 4'd2;
  localparam logic [3:0] S_SWP_RD   = 4'd3;
  localparam logic [3:0] S_SWP      = 4'd4;
  localparam logic [3:0] S_VIC      = 4'd5;
  localparam logic [3:0] S_VIC_LINK = 4'd6;
  localparam logic [3:0] S_TRIM     = 4'd7;
  localparam logic [3:0] S_DROP_RD  = 4'd8;
  localparam logic [3:0] S_DROP     = 4'd9;
  localparam logic [3:0] S_ADAPT    = 4'd10;
  localparam logic [3:0] S_DIV      = 4'd11;
  localparam logic [3:0] S_UNL_RD   = 4'd12;
  localparam logic [3:0] S_UNL      = 4'd13;
  localparam logic [3:0] S_INS      = 4'd14;
  localparam logic [3:0] S_EMIT     = 4'd15;

  // Control registers
  logic [3:0]          state;
  logic [PNB-1:0]      clr;
  logic [PNB-1:0]      pg;
  car_pkg::cls_t       cls;
  logic [IW-1:0]       idx;
  logic [PNB-1:0]      vpg;
  logic                vc;
  logic [NB-1:0]       vn;
  logic [NB:0]         ltail;
  logic                dropl;
  logic [FB-1:0]       hd [2];
  logic [CW-1:0]       cnt [2];
  logic [NB:0]         gh [2];
  logic [NB:0]         gt [2];
  logic [GW-1:0]       gc [2];
  logic [GW-1:0]       gfresh;
  logic [NB-1:0]       gfh;
  logic [GW-1:0]       gfc;
  logic [CW-1:0]       fff;
  logic [FB-1:0]       ffh;
  logic [CW-1:0]       ffc;
  logic [CW-1:0]       p;
  logic                dl;
  logic [GW-1:0]       dnum;
  logic [GW-1:0]       dden;
  logic [GW:0]         drem;
  logic [DSW-1:0]      dstep;
  logic [FB-1:0]       ld_frame;
  logic                out_valid;
  logic [FB-1:0]       out_frame;
  logic [PNB-1:0]      out_page;

  // RAM ports
  logic              dir_we;
  logic [PNB-1:0]    dir_waddr, dir_raddr;
  logic [DW-1:0]     dir_wdata, dir_rdata;
  logic              cp_we;
  logic [FB:0]       cp_waddr, cp_raddr;
  logic [CPW-1:0]    cp_wdata, cp_rdata;
  logic              cr_we;
  logic [FB:0]       cr_waddr;
  logic [0:0]        cr_wdata, cr_rdata;
  logic              np_we;
  logic [NB-1:0]     np_waddr, node_raddr;
  logic [PNB-1:0]    np_wdata, np_rdata;
  logic              nv_we;
  logic [NB-1:0]     nv_waddr;
  logic [NB:0]       nv_wdata, nv_rdata;
  logic              nn_we;
  logic [NB-1:0]     nn_waddr;
  logic [NB:0]       nn_wdata, nn_rdata;
  logic              gf_we;
  logic [NB-1:0]     gf_waddr;
  logic [NB-1:0]     gf_wdata, gf_rdata;
  logic              ff_we;
  logic [FB-1:0]     ff_waddr;
  logic [FB-1:0]     ff_wdata, ff_rdata;

  // Shared combinational values
  logic [car_pkg::ADDRESS_W-1:0] addr_sh;
  logic [PNB-1:0]  page_in;
  logic [CW-1:0]   lim;
  logic            swc;
  logic            sw_none;
  logic [FB-1:0]   slot1;
  logic            ins_c;
  logic [FB-1:0]   ins_slot;
  logic [FB-1:0]   ins_frame;
  logic            vic_avail;
  logic [NB-1:0]   vic_n;
  logic [NB-1:0]   gf_tail;
  logic [FB-1:0]   ff_tail;
  logic [CW:0]     occ;
  logic            trim0, trim1;
  logic            is_ghost;
  logic            dir_hit;
  logic [GW-1:0]   q, st;
  logic [SW-1:0]   psum;
  logic [CW-1:0]   p_adapt;
  logic [GW:0]     rem_sh;
  logic            qbit;
  car_pkg::cls_t   rd_cls;

  function automatic logic [FB-1:0] fwrap(input logic [CW:0] s);
    logic [CW:0] t;
    t = (s >= (CW+1)'(FRAMES)) ? s - (CW+1)'(FRAMES) : s;
    return t[FB-1:0];
  endfunction

  function automatic logic [NB-1:0] gwrap(input logic [GW:0] s);
    logic [GW:0] t;
    t = (s >= (GW+1)'(GHOST_LIMIT)) ? s - (GW+1)'(GHOST_LIMIT) : s;
    return t[NB-1:0];
  endfunction

  function automatic logic [FB-1:0] finc(input logic [FB-1:0] h);
    return (h == FB'(FRAMES - 1)) ? '0 : h + FB'(1);
  endfunction

  // Page number of the request word
  assign addr_sh = req.address >> PAGE_OFFSET_BITS;
  assign page_in = addr_sh[PNB-1:0];

  assign rd_cls   = dir_rdata[DW-1:IW];
  assign dir_hit  = (rd_cls == car_pkg::CLS_T1) || (rd_cls == car_pkg::CLS_T2);
  assign is_ghost = (cls == car_pkg::CLS_B1) || (cls == car_pkg::CLS_B2);
  assign occ      = (CW+1)'(cnt[0]) + (CW+1)'(cnt[1]);

  // Sweep side: recent clock when it reaches the target, else frequent
  always_comb begin
    lim = (p > CW'(1)) ? p : CW'(1);
    swc = (cnt[0] >= lim) ? 1'b0 : 1'b1;
    if (cnt[swc] == '0) begin
      swc = ~swc;
    end
    sw_none = (cnt[0] == '0) && (cnt[1] == '0);
  end

  assign slot1    = fwrap((CW+1)'(hd[1]) + (CW+1)'(cnt[1]));
  assign ins_c    = is_ghost;
  assign ins_slot = fwrap((CW+1)'(hd[ins_c]) + (CW+1)'(cnt[ins_c]));
  assign gf_tail  = gwrap((GW+1)'(gfh) + (GW+1)'(gfc));
  assign ff_tail  = fwrap((CW+1)'(ffh) + (CW+1)'(ffc));

  // Frame pop: never-used frames first, then the released ones in order
  always_comb begin
    if (fff < CW'(FRAMES)) begin
      ins_frame = fff[FB-1:0];
    end else if (ffc != '0) begin
      ins_frame = ff_rdata;
    end else begin
      ins_frame = '0;
    end
  end

  // Ghost node pop, same order rule
  assign vic_avail = (gfresh < GW'(GHOST_LIMIT)) || (gfc != '0);
  assign vic_n     = (gfresh < GW'(GHOST_LIMIT)) ? gfresh[NB-1:0] : gf_rdata;

  // Directory trim conditions
  assign trim0 = ((TW'(cnt[0]) + TW'(gc[0])) >= TW'(FRAMES)) && (gc[0] != '0);
  assign trim1 = ((TW'(cnt[0]) + TW'(cnt[1]) + TW'(gc[0]) + TW'(gc[1]))
                  >= TW'(GHOST_LIMIT)) && (gc[1] != '0);

  // Target step from the quotient
  always_comb begin
    q    = (dden == '0) ? '0 : dnum;
    st   = (q > GW'(1)) ? q : GW'(1);
    psum = SW'(p) + SW'(st);
    if (!dl) begin
      p_adapt = (psum > SW'(FRAMES)) ? CW'(FRAMES) : psum[CW-1:0];
    end else begin
      p_adapt = (SW'(p) > SW'(st)) ? CW'(SW'(p) - SW'(st)) : '0;
    end
  end

  // Restoring divider step
  assign rem_sh = {drem[GW-1:0], dnum[GW-1]};
  assign qbit   = (rem_sh >= (GW+1)'(dden));

  // Read addresses
  assign dir_raddr  = page_in;
  assign cp_raddr   = {swc, hd[swc]};
  assign node_raddr = (state == S_DROP_RD) ? gh[dropl][NB-1:0] : idx[NB-1:0];

  // Write ports of every RAM
  always_comb begin
    dir_we    = 1'b0;
    dir_waddr = pg;
    dir_wdata = '0;
    cp_we     = 1'b0;
    cp_waddr  = {ins_c, ins_slot};
    cp_wdata  = {pg, ins_frame};
    cr_we     = 1'b0;
    cr_waddr  = {ins_c, ins_slot};
    cr_wdata  = 1'b0;
    np_we     = 1'b0;
    np_waddr  = vic_n;
    np_wdata  = vpg;
    nv_we     = 1'b0;
    nv_waddr  = vic_n;
    nv_wdata  = gt[vc];
    nn_we     = 1'b0;
    nn_waddr  = vic_n;
    nn_wdata  = NIL;
    gf_we     = 1'b0;
    gf_waddr  = gf_tail;
    gf_wdata  = idx[NB-1:0];
    ff_we     = 1'b0;
    ff_waddr  = ff_tail;
    ff_wdata  = cp_rdata[FB-1:0];
    unique case (state)
      S_CLEAR: begin
        dir_we    = 1'b1;
        dir_waddr = clr;
        dir_wdata = {car_pkg::CLS_ABSENT, {IW{1'b0}}};
      end
      S_DIR: begin
        cr_we    = dir_hit;
        cr_waddr = {rd_cls == car_pkg::CLS_T2, dir_rdata[FB-1:0]};
        cr_wdata = 1'b1;
      end
      S_SWP: begin
        if (cr_rdata[0]) begin
          // referenced: move to the tail of the frequent clock
          cp_we     = 1'b1;
          cp_waddr  = {1'b1, slot1};
          cp_wdata  = cp_rdata;
          cr_we     = 1'b1;
          cr_waddr  = {1'b1, slot1};
          dir_we    = 1'b1;
          dir_waddr = cp_rdata[CPW-1:FB];
          dir_wdata = {car_pkg::CLS_T2, IW'(slot1)};
        end else begin
          ff_we = 1'b1;
        end
      end
      S_VIC: begin
        dir_we    = 1'b1;
        dir_waddr = vpg;
        if (vic_avail) begin
          np_we     = 1'b1;
          nv_we     = 1'b1;
          nn_we     = 1'b1;
          dir_wdata = {vc ? car_pkg::CLS_B2 : car_pkg::CLS_B1, IW'(vic_n)};
        end else begin
          dir_wdata = {car_pkg::CLS_ABSENT, {IW{1'b0}}};
        end
      end
      S_VIC_LINK: begin
        nn_we    = !ltail[NB];
        nn_waddr = ltail[NB-1:0];
        nn_wdata = {1'b0, vn};
      end
      S_DROP: begin
        dir_we    = 1'b1;
        dir_waddr = np_rdata;
        dir_wdata = {car_pkg::CLS_ABSENT, {IW{1'b0}}};
        nv_we     = !nn_rdata[NB];
        nv_waddr  = nn_rdata[NB-1:0];
        nv_wdata  = NIL;
        gf_we     = 1'b1;
        gf_wdata  = gh[dropl][NB-1:0];
      end
      S_UNL: begin
        nn_we    = !nv_rdata[NB];
        nn_waddr = nv_rdata[NB-1:0];
        nn_wdata = nn_rdata;
        nv_we    = !nn_rdata[NB];
        nv_waddr = nn_rdata[NB-1:0];
        nv_wdata = nv_rdata;
        gf_we    = 1'b1;
      end
      S_INS: begin
        cp_we     = 1'b1;
        cr_we     = 1'b1;
        dir_we    = 1'b1;
        dir_wdata = {ins_c ? car_pkg::CLS_T2 : car_pkg::CLS_T1, IW'(ins_slot)};
      end
      default: begin
      end
    endcase
  end

  // Sequencer and list bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      hd[0]     <= '0;
      hd[1]     <= '0;
      cnt[0]    <= '0;
      cnt[1]    <= '0;
      gh[0]     <= NIL;
      gh[1]     <= NIL;
      gt[0]     <= NIL;
      gt[1]     <= NIL;
      gc[0]     <= '0;
      gc[1]     <= '0;
      gfresh    <= '0;
      gfh       <= '0;
      gfc       <= '0;
      fff       <= '0;
      ffh       <= '0;
      ffc       <= '0;
      p         <= '0;
      out_valid <= 1'b0;
    end else begin
      // raise the response word on emit, drop it once taken
      if ((state == S_EMIT) && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + PNB'(1);
          if (&clr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          pg <= page_in;
          if (req.valid) begin
            state <= S_DIR;
          end
        end
        S_DIR: begin
          cls <= rd_cls;
          idx <= dir_rdata[IW-1:0];
          if (dir_hit) begin
            state <= S_IDLE;
          end else if (occ >= (CW+1)'(FRAMES)) begin
            state <= S_SWP_RD;
          end else if ((rd_cls == car_pkg::CLS_B1) || (rd_cls == car_pkg::CLS_B2)) begin
            state <= S_ADAPT;
          end else begin
            state <= S_INS;
          end
        end
        S_SWP_RD: begin
          if (sw_none) begin
            state <= S_TRIM;
          end else begin
            vc       <= swc;
            hd[swc]  <= finc(hd[swc]);
            cnt[swc] <= cnt[swc] - CW'(1);
            state    <= S_SWP;
          end
        end
        S_SWP: begin
          if (cr_rdata[0]) begin
            cnt[1] <= cnt[1] + CW'(1);
            state  <= S_SWP_RD;
          end else begin
            ffc   <= ffc + CW'(1);
            vpg   <= cp_rdata[CPW-1:FB];
            state <= S_VIC;
          end
        end
        S_VIC: begin
          if (vic_avail) begin
            if (gfresh < GW'(GHOST_LIMIT)) begin
              gfresh <= gfresh + GW'(1);
            end else begin
              gfh <= gwrap((GW+1)'(gfh) + (GW+1)'(1));
              gfc <= gfc - GW'(1);
            end
            vn     <= vic_n;
            ltail  <= gt[vc];
            gt[vc] <= {1'b0, vic_n};
            gc[vc] <= gc[vc] + GW'(1);
            if (gt[vc][NB]) begin
              gh[vc] <= {1'b0, vic_n};
            end
          end else begin
            ltail <= NIL;
          end
          state <= S_VIC_LINK;
        end
        S_VIC_LINK: begin
          state <= S_TRIM;
        end
        S_TRIM: begin
          if (is_ghost) begin
            state <= S_ADAPT;
          end else if (trim0) begin
            dropl <= 1'b0;
            state <= S_DROP_RD;
          end else if (trim1) begin
            dropl <= 1'b1;
            state <= S_DROP_RD;
          end else begin
            state <= S_INS;
          end
        end
        S_DROP_RD: begin
          state <= S_DROP;
        end
        S_DROP: begin
          gh[dropl] <= nn_rdata;
          if (nn_rdata[NB]) begin
            gt[dropl] <= NIL;
          end
          gc[dropl] <= gc[dropl] - GW'(1);
          gfc       <= gfc + GW'(1);
          state     <= S_INS;
        end
        S_ADAPT: begin
          dl    <= (cls == car_pkg::CLS_B2);
          dnum  <= (cls == car_pkg::CLS_B2) ? gc[0] : gc[1];
          dden  <= (cls == car_pkg::CLS_B2) ? gc[1] : gc[0];
          drem  <= '0;
          dstep <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          drem  <= qbit ? rem_sh - (GW+1)'(dden) : rem_sh;
          dnum  <= {dnum[GW-2:0], qbit};
          dstep <= dstep + DSW'(1);
          if (dstep == DSW'(GW - 1)) begin
            state <= S_UNL_RD;
          end
        end
        S_UNL_RD: begin
          p     <= p_adapt;
          state <= S_UNL;
        end
        S_UNL: begin
          if (nv_rdata[NB]) begin
            gh[dl] <= nn_rdata;
          end
          if (nn_rdata[NB]) begin
            gt[dl] <= nv_rdata;
          end
          gc[dl] <= gc[dl] - GW'(1);
          gfc    <= gfc + GW'(1);
          state  <= S_INS;
        end
        S_INS: begin
          if (fff < CW'(FRAMES)) begin
            fff <= fff + CW'(1);
          end else if (ffc != '0) begin
            ffh <= finc(ffh);
            ffc <= ffc - CW'(1);
          end
          cnt[ins_c] <= cnt[ins_c] + CW'(1);
          ld_frame   <= ins_frame;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || rsp.ready) begin
            out_frame <= ld_frame;
            out_page  <= pg;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.frame = out_frame;
  assign rsp.page  = out_page;

  // State memories
  car_ram #(.WIDTH(DW), .ADDR_W(PNB)) u_dir (
    .clk(clk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
    .raddr(dir_raddr), .rdata(dir_rdata)
  );

  car_ram #(.WIDTH(CPW), .ADDR_W(FB + 1)) u_clk_page (
    .clk(clk), .we(cp_we), .waddr(cp_waddr), .wdata(cp_wdata),
    .raddr(cp_raddr), .rdata(cp_rdata)
  );

  car_ram #(.WIDTH(1), .ADDR_W(FB + 1)) u_clk_ref (
    .clk(clk), .we(cr_we), .waddr(cr_waddr), .wdata(cr_wdata),
    .raddr(cp_raddr), .rdata(cr_rdata)
  );

  car_ram #(.WIDTH(PNB), .ADDR_W(NB)) u_node_page (
    .clk(clk), .we(np_we), .waddr(np_waddr), .wdata(np_wdata),
    .raddr(node_raddr), .rdata(np_rdata)
  );

  car_ram #(.WIDTH(NB + 1), .ADDR_W(NB)) u_node_prev (
    .clk(clk), .we(nv_we), .waddr(nv_waddr), .wdata(nv_wdata),
    .raddr(node_raddr), .rdata(nv_rdata)
  );

  car_ram #(.WIDTH(NB + 1), .ADDR_W(NB)) u_node_next (
    .clk(clk), .we(nn_we), .waddr(nn_waddr), .wdata(nn_wdata),
    .raddr(node_raddr), .rdata(nn_rdata)
  );

  car_ram #(.WIDTH(NB), .ADDR_W(NB)) u_ghost_free (
    .clk(clk), .we(gf_we), .waddr(gf_waddr), .wdata(gf_wdata),
    .raddr(gfh), .rdata(gf_rdata)
  );

  car_ram #(.WIDTH(FB), .ADDR_W(FB)) u_frame_free (
    .clk(clk), .we(ff_we), .waddr(ff_waddr), .wdata(ff_wdata),
    .raddr(ffh), .rdata(ff_rdata)
  );

  // Checks
  a_clock_occupancy: assert property (@(posedge clk) disable iff (rst)
    occ <= (CW+1)'(FRAMES))
    else $error("clock occupancy exceeds frame count");

  a_ghost_pool: assert property (@(posedge clk) disable iff (rst)
    ((GW+2)'(gc[0]) + (GW+2)'(gc[1]) + (GW+2)'(gfc)) == (GW+2)'(gfresh))
    else $error("ghost node pool lost or duplicated a node");

  a_target_range: assert property (@(posedge clk) disable iff (rst)
    p <= CW'(FRAMES))
    else $error("adaptive target out of range");

  a_accept_lookup: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_DIR))
    else $error("accepted word did not start a directory lookup");

endmodule

// ----- bench/car_page_replacement_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CAR page replacement engine testbench
// Drives address words in random bursts, predicts every loaded frame and page
// with an in-bench CAR directory, and checks each response word in order.
// ----------------------------------------------------------------------------
module car_page_replacement_top_test;

  localparam int NFRAMES = car_pkg::FRAMES_DEF;
  localparam int NGHOST  = car_pkg::GHOST_LIMIT_DEF;
  localparam int NIL     = 16'hFFFF;
  localparam int LOADS   = 1050;

  typedef struct packed {
    logic [5:0]  frame;
    logic [19:0] page;
  } load_t;

  // Scoreboard: a CAR directory of its own plus the queue of pending loads
  class car_scoreboard;
    load_t          loads_q[$];
    int             errors;
    car_pkg::cls_t  dir_cls[int];
    int       dir_slot[int];
    int       dir_frame[int];
    int       dir_node[int];
    int       ring_page[2][NFRAMES];
    bit       ring_ref[2][NFRAMES];
    int       ring_head[2];
    int       ring_count[2];
    int       node_page[NGHOST];
    int       node_prev[NGHOST];
    int       node_next[NGHOST];
    int       ghost_head[2];
    int       ghost_tail[2];
    int       ghost_count[2];
    int       node_free[NGHOST];
    int       node_free_head;
    int       node_free_count;
    int       frame_free[NFRAMES];
    int       frame_free_head;
    int       frame_free_count;
    int       target;

    function new();
      errors = 0;
      for (int i = 0; i < 2; i++) begin
        ring_head[i] = 0; ring_count[i] = 0;
        ghost_head[i] = NIL; ghost_tail[i] = NIL; ghost_count[i] = 0;
      end
      for (int i = 0; i < NGHOST; i++) node_free[i] = i;
      node_free_head = 0; node_free_count = NGHOST;
      for (int i = 0; i < NFRAMES; i++) frame_free[i] = i;
      frame_free_head = 0; frame_free_count = NFRAMES;
      target = 0;
    endfunction

    function car_pkg::cls_t class_of(int pg);
      return dir_cls.exists(pg) ? dir_cls[pg] : car_pkg::CLS_ABSENT;
    endfunction

    function void ring_append(int c, int pg);
      int slot;
      if (ring_count[c] >= NFRAMES) return;
      slot = (ring_head[c] + ring_count[c]) % NFRAMES;
      ring_page[c][slot] = pg;
      ring_ref[c][slot]  = 0;
      dir_slot[pg] = slot;
      dir_cls[pg]  = c ? car_pkg::CLS_T2 : car_pkg::CLS_T1;
      ring_count[c]++;
    endfunction

    function void ghost_unlink(int l, int n);
      int pv, nx;
      if (n >= NGHOST) return;
      pv = node_prev[n];
      nx = node_next[n];
      if (pv == NIL) ghost_head[l] = nx; else node_next[pv] = nx;
      if (nx == NIL) ghost_tail[l] = pv; else node_prev[nx] = pv;
      if (ghost_count[l] > 0) ghost_count[l]--;
      if (node_free_count < NGHOST) begin
        node_free[(node_free_head + node_free_count) % NGHOST] = n;
        node_free_count++;
      end
    endfunction

    function void ghost_append(int l, int pg);
      int n;
      if (node_free_count == 0) begin
        dir_cls[pg] = car_pkg::CLS_ABSENT;
        return;
      end
      n = node_free[node_free_head];
      node_free_head = (node_free_head + 1) % NGHOST;
      node_free_count--;
      node_page[n] = pg;
      node_next[n] = NIL;
      node_prev[n] = ghost_tail[l];
      if (ghost_tail[l] == NIL) ghost_head[l] = n; else node_next[ghost_tail[l]] = n;
      ghost_tail[l] = n;
      ghost_count[l]++;
      dir_node[pg] = n;
      dir_cls[pg]  = l ? car_pkg::CLS_B2 : car_pkg::CLS_B1;
    endfunction

    function void ghost_trim(int l);
      int n;
      n = ghost_head[l];
      if (n == NIL || n >= NGHOST) return;
      dir_cls[node_page[n]] = car_pkg::CLS_ABSENT;
      ghost_unlink(l, n);
    endfunction

    // Sweep the clocks until an unreferenced victim is retired
    function void evict_one();
      int lim, c, h, pg;
      forever begin
        lim = target > 1 ? target : 1;
        c = (ring_count[0] >= lim) ? 0 : 1;
        if (ring_count[c] == 0) c ^= 1;
        if (ring_count[c] == 0) return;
        h  = ring_head[c];
        pg = ring_page[c][h];
        ring_head[c] = (h + 1) % NFRAMES;
        ring_count[c]--;
        if (!ring_ref[c][h]) begin
          if (frame_free_count < NFRAMES) begin
            frame_free[(frame_free_head + frame_free_count) % NFRAMES] = dir_frame[pg];
            frame_free_count++;
          end
          ghost_append(c, pg);
          return;
        end
        ring_append(1, pg);
      end
    endfunction

    // Note an accepted address word and predict its load, if any
    function void note_address(logic [31:0] address);
      int             pg, q, st, fr;
      car_pkg::cls_t  cls;
      pg  = int'(address[31:12]);
      cls = class_of(pg);
      if (cls == car_pkg::CLS_T1 || cls == car_pkg::CLS_T2) begin
        ring_ref[cls == car_pkg::CLS_T2][dir_slot[pg]] = 1;
        return;
      end
      if (ring_count[0] + ring_count[1] >= NFRAMES) begin
        evict_one();
        if (cls != car_pkg::CLS_B1 && cls != car_pkg::CLS_B2) begin
          if (ring_count[0] + ghost_count[0] >= NFRAMES && ghost_count[0] > 0)
            ghost_trim(0);
          else if (ring_count[0] + ring_count[1] + ghost_count[0] + ghost_count[1] >= NGHOST
                   && ghost_count[1] > 0)
            ghost_trim(1);
        end
      end
      if (cls == car_pkg::CLS_B1) begin
        q  = ghost_count[0] ? ghost_count[1] / ghost_count[0] : 0;
        st = q > 1 ? q : 1;
        target = (target + st > NFRAMES) ? NFRAMES : target + st;
        ghost_unlink(0, dir_node[pg]);
        ring_append(1, pg);
      end else if (cls == car_pkg::CLS_B2) begin
        q  = ghost_count[1] ? ghost_count[0] / ghost_count[1] : 0;
        st = q > 1 ? q : 1;
        target = (target > st) ? target - st : 0;
        ghost_unlink(1, dir_node[pg]);
        ring_append(1, pg);
      end else begin
        ring_append(0, pg);
      end
      fr = 0;
      if (frame_free_count > 0) begin
        fr = frame_free[frame_free_head];
        frame_free_head = (frame_free_head + 1) % NFRAMES;
        frame_free_count--;
      end
      dir_frame[pg] = fr;
      loads_q.push_back('{frame: fr[5:0], page: pg[19:0]});
    endfunction

    // Check a response word against the oldest pending load
    function void check_load(logic [5:0] frame, logic [19:0] page);
      load_t exp_load;
      if (loads_q.size() == 0) begin
        $error("unexpected response frame=%0d page=%h", frame, page);
        errors++;
        return;
      end
      exp_load = loads_q.pop_front();
      if (frame !== exp_load.frame) begin
        $error("frame: expected %0d, actual %0d", exp_load.frame, frame);
        errors++;
      end
      if (page !== exp_load.page) begin
        $error("page: expected %h, actual %h", exp_load.page, page);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;

  car_req_if req ();
  car_rsp_if #(.FRAME_W(6), .PAGE_W(20)) rsp ();

  car_page_replacement_top DUT (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  car_scoreboard sb = new();
  logic [19:0]   page_pool[400];
  int            cycle_cnt = 0;

  always #1 clk = ~clk;

  // Hold reset at start, then release it
  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
  end

  // Stall the receiver: alternate free-running and choppy windows
  initial rsp.ready = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    case ((cycle_cnt / 700) % 3)
      0: begin
        rsp.ready <= 1'b1;
      end
      1: begin
        rsp.ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        rsp.ready <= (cycle_cnt % 11) > 6;
      end
    endcase
  end

  // Note accepted words on both channels
  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) sb.note_address(req.address);
    if (!rst && rsp.valid && rsp.ready) sb.check_load(rsp.frame, rsp.page);
  end

  int burst_left = 0;

  // Offer one address word and hold it until taken; sometimes idle between bursts
  task automatic send_address(logic [31:0] address);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    req.valid   <= 1'b1;
    req.address <= address;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  function automatic logic [31:0] pool_address(int span);
    return {page_pool[$urandom_range(0, span - 1)], 12'($urandom)};
  endfunction

  initial begin
    int span;
    req.valid   = 0;
    req.address = 0;
    for (int i = 0; i < 400; i++) page_pool[i] = 20'($urandom);
    @(posedge clk);
    while (rst) @(posedge clk);

    // Directed: field extremes, hits on the same page, then more new pages
    send_address(32'h0000_0000);
    send_address(32'h0000_0FFF);
    send_address(32'hFFFF_FFFF);
    send_address(32'hFFFF_F000);
    send_address(32'h8000_0000);
    send_address(32'h0000_1000);
    send_address(32'h7FFF_FFFF);
    for (int i = 0; i < 16; i++) send_address({20'(i * 4099 + 17), 12'($urandom)});

    // Random: working sets of varying size drive hits, evictions and ghost hits
    for (int n = 0; n < LOADS; n++) begin
      span = (n / 150) % 3 == 0 ? 90 : ((n / 150) % 3 == 1 ? 180 : 400);
      if ($urandom_range(0, 9) == 0) send_address($urandom);
      else send_address(pool_address(span));
    end
    req.valid <= 1'b0;

    while (sb.loads_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.loads_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Bound the run: directory clear plus the slowest sweeps, many times over
  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule
